[rtl/core/lcr_pkg.sv]
// shared constants, types and helper functions for the lon/lat covariance rotation
package lcr_pkg;

   // default binary angle resolution of the sin/cos units
   localparam int ANGLE_BITS_DEFAULT = 16;

   // scale register reset value (about 1/6371000 in Q.48)
   localparam logic [31:0] SCALE_RESET = 32'd44180815;

   // cordic gain compensation and unity in Q30
   localparam logic signed [32:0] CORDIC_K = 33'sd652032874;
   localparam logic signed [32:0] ONE_Q30 = 33'sd1073741824;

   // secant divider: quotient bits of 2^60 / |cos|
   localparam int DIV_BITS = 61;
   localparam int DEN_W = 31;

   // saturation limits
   localparam logic [63:0] LIM_U64 = 64'hFFFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] LIM_POS = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] LIM_NEG = 64'h8000_0000_0000_0000;

   typedef logic [127:0] prod_type;

   // arctangent of 2^-i as a Q30 fraction of a quarter turn
   function automatic logic signed [32:0] atan_q30(input int i);
      logic signed [32:0] r;
      unique case (i)
         0: r = 33'sd536870912;
         1: r = 33'sd316933405;
         2: r = 33'sd167458907;
         3: r = 33'sd85005780;
         4: r = 33'sd42667331;
         5: r = 33'sd21354465;
         6: r = 33'sd10679838;
         7: r = 33'sd5340245;
         8: r = 33'sd2670163;
         9: r = 33'sd1335086;
         10: r = 33'sd667544;
         11: r = 33'sd333772;
         12: r = 33'sd166886;
         13: r = 33'sd83443;
         14: r = 33'sd41721;
         15: r = 33'sd20860;
         16: r = 33'sd10430;
         17: r = 33'sd5215;
         18: r = 33'sd2607;
         19: r = 33'sd1303;
         20: r = 33'sd651;
         21: r = 33'sd325;
         22: r = 33'sd162;
         23: r = 33'sd81;
         default: r = 33'sd0;
      endcase
      return r;
   endfunction

   // shift a 128-bit product right and saturate to a limit
   function automatic logic [63:0] shr_sat(input prod_type prod, input int shift,
                                           input logic [63:0] lim);
      prod_type v;
      v = prod >> shift;
      if (v[127:64] != 64'd0 || v[63:0] > lim) begin
         return lim;
      end
      return v[63:0];
   endfunction

endpackage

[rtl/core/lcr_mul.sv]
// two-stage 64x64 unsigned multiplier built from four 32x32 partial products
module lcr_mul (
   input  logic                 clock,
   input  logic                 en,
   input  logic [63:0]          a,
   input  logic [63:0]          b,
   output lcr_pkg::prod_type    prod
);
   import lcr_pkg::*;

   logic [63:0] pp00_ff, pp01_ff, pp10_ff, pp11_ff;
   prod_type    prod_ff;

   // partial products
   always_ff @(posedge clock) begin
      if (en) begin
         pp00_ff <= 64'(a[31:0]) * 64'(b[31:0]);
         pp01_ff <= 64'(a[31:0]) * 64'(b[63:32]);
         pp10_ff <= 64'(a[63:32]) * 64'(b[31:0]);
         pp11_ff <= 64'(a[63:32]) * 64'(b[63:32]);
      end
   end

   // partial product sum
   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= {64'd0, pp00_ff} + {32'd0, pp01_ff, 32'd0}
                  + {32'd0, pp10_ff, 32'd0} + {pp11_ff, 64'd0};
      end
   end

   assign prod = prod_ff;

endmodule

[rtl/core/lcr_cordic.sv]
// pipelined cordic: binary angle phase to Q30 cosine and sine, one rotation per stage
module lcr_cordic #(
   parameter int ANGLE_BITS = lcr_pkg::ANGLE_BITS_DEFAULT
) (
   input  logic               clock,
   input  logic               en,
   input  logic [31:0]        phase,
   output logic signed [31:0] cos_q30,
   output logic signed [31:0] sin_q30
);
   import lcr_pkg::*;

   localparam logic [31:0] PHASE_MASK = ~((32'd1 << (32 - ANGLE_BITS)) - 32'd1);

   logic [31:0]        phase_m;
   logic [31:0]        phase_off;
   logic [1:0]         quad;
   logic [31:0]        resid;
   logic signed [32:0] x_ff [ANGLE_BITS+1];
   logic signed [32:0] y_ff [ANGLE_BITS+1];
   logic signed [32:0] z_ff [ANGLE_BITS+1];
   logic [1:0]         q_ff [ANGLE_BITS+1];
   logic signed [32:0] xc, yc;
   logic signed [31:0] cos_ff, sin_ff;

   // fold the phase into one octant pair plus a quadrant
   always_comb begin
      phase_m   = phase & PHASE_MASK;
      phase_off = phase_m + 32'h2000_0000;
      quad      = phase_off[31:30];
      resid     = phase_m - {quad, 30'd0};
   end

   // setup stage and micro-rotations
   always_ff @(posedge clock) begin
      if (en) begin
         x_ff[0] <= CORDIC_K;
         y_ff[0] <= 33'sd0;
         z_ff[0] <= signed'({resid[31], resid});
         q_ff[0] <= quad;
         for (int i = 0; i < ANGLE_BITS; i++) begin
            if (z_ff[i][32]) begin
               x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] + atan_q30(i);
            end else begin
               x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] - atan_q30(i);
            end
            q_ff[i+1] <= q_ff[i];
         end
      end
   end

   // clamp to unity
   always_comb begin
      xc = x_ff[ANGLE_BITS];
      if (xc > ONE_Q30) xc = ONE_Q30;
      if (xc < -ONE_Q30) xc = -ONE_Q30;
      yc = y_ff[ANGLE_BITS];
      if (yc > ONE_Q30) yc = ONE_Q30;
      if (yc < -ONE_Q30) yc = -ONE_Q30;
   end

   // quadrant restore
   always_ff @(posedge clock) begin
      if (en) begin
         unique case (q_ff[ANGLE_BITS])
            2'd0: begin
               cos_ff <= 32'(xc);
               sin_ff <= 32'(yc);
            end
            2'd1: begin
               cos_ff <= 32'(-yc);
               sin_ff <= 32'(xc);
            end
            2'd2: begin
               cos_ff <= 32'(-xc);
               sin_ff <= 32'(-yc);
            end
            default: begin
               cos_ff <= 32'(yc);
               sin_ff <= 32'(-xc);
            end
         endcase
      end
   end

   assign cos_q30 = cos_ff;
   assign sin_q30 = sin_ff;

endmodule

[rtl/core/lcr_div.sv]
// pipelined restoring divider: 2^60 / den, one quotient bit per stage
module lcr_div (
   input  logic                              clock,
   input  logic                              en,
   input  logic [lcr_pkg::DEN_W-1:0]         den,
   output logic [lcr_pkg::DIV_BITS-1:0]      quot
);
   import lcr_pkg::*;

   logic [DEN_W-1:0]    rem_ff [DIV_BITS];
   logic [DEN_W-1:0]    den_ff [DIV_BITS];
   logic [DIV_BITS-1:0] q_ff   [DIV_BITS];
   logic [DEN_W-1:0]    rem_src [DIV_BITS];
   logic [DEN_W-1:0]    den_src [DIV_BITS];
   logic [DIV_BITS-1:0] q_src   [DIV_BITS];
   logic [DEN_W:0]      sh_w    [DIV_BITS];
   logic [DEN_W-1:0]    rem_nx  [DIV_BITS];
   logic [DIV_BITS-1:0] q_nx    [DIV_BITS];

   // one trial subtraction per stage; the dividend has a single leading one
   always_comb begin
      rem_src[0] = '0;
      den_src[0] = den;
      q_src[0]   = '0;
      for (int k = 1; k < DIV_BITS; k++) begin
         rem_src[k] = rem_ff[k-1];
         den_src[k] = den_ff[k-1];
         q_src[k]   = q_ff[k-1];
      end
      for (int k = 0; k < DIV_BITS; k++) begin
         sh_w[k] = {rem_src[k], (k == 0)};
         if (sh_w[k] >= {1'b0, den_src[k]}) begin
            rem_nx[k] = DEN_W'(sh_w[k] - {1'b0, den_src[k]});
            q_nx[k]   = {q_src[k][DIV_BITS-2:0], 1'b1};
         end else begin
            rem_nx[k] = sh_w[k][DEN_W-1:0];
            q_nx[k]   = {q_src[k][DIV_BITS-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < DIV_BITS; k++) begin
            rem_ff[k] <= rem_nx[k];
            den_ff[k] <= den_src[k];
            q_ff[k]   <= q_nx[k];
         end
      end
   end

   assign quot = q_ff[DIV_BITS-1];

endmodule

[rtl/core/lonlat_covariance_rotation_top.sv]
// top level of the lon/lat covariance rotation pipeline
// One item enters per cycle while the pipeline is not held. On the way the two sin/cos
// units take ANGLE_BITS + 2 stages, the secant divider takes 61 stages (one quotient
// bit each), and the 64x64 multipliers take two stages plus one for shift and
// saturation, two in a row after the divider.
// The whole pipeline holds while a result waits under rsp_stall; req_stall follows.
// The scale register is written through csr_wdata, which is always ready; it must
// only change while no item is in flight.
module lonlat_covariance_rotation_top #(
   parameter int ANGLE_BITS = lcr_pkg::ANGLE_BITS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [15:0]        req_bearing,
   input  logic signed [14:0] req_latitude,
   input  logic [15:0]        req_sigma_cross_m,
   input  logic [15:0]        req_sigma_down_m,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [63:0]        rsp_cov_lon_lon,
   output logic [63:0]        rsp_cov_lat_lat,
   output logic signed [63:0] rsp_cov_lon_lat,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [31:0]        csr_wdata
);
   import lcr_pkg::*;

   localparam int CORDIC_LAT = ANGLE_BITS + 2;
   localparam int VC_DLY     = CORDIC_LAT - 4;
   localparam int HOLD_DLY   = DIV_BITS - 3;
   localparam int NUM_STAGES = ANGLE_BITS + 3 + DIV_BITS + 7;

   logic        en;
   logic [31:0] scale_ff;
   logic        v_ff [NUM_STAGES];

   logic [15:0]        bearing_ff;
   logic signed [14:0] lat_ff;
   logic [15:0]        sig_c_ff, sig_d_ff;
   logic [31:0]        brg_phase, lat_phase;
   logic signed [31:0] ca, sa, cl;

   logic [47:0] sc_ff, sd_ff;
   prod_type    vc_prod, vd_prod;
   logic [63:0] vc_ff, vd_ff;
   logic [63:0] vc_dly_ff [VC_DLY];
   logic [63:0] vd_dly_ff [VC_DLY];
   logic [63:0] vc_c, vd_c;

   logic [31:0]      ca_abs, sa_abs, cl_abs;
   logic [61:0]      cos_sq, sin_sq, cs_pr;
   logic [30:0]      cos2_ff, sin2_ff, cs_ff;
   logic [DEN_W-1:0] den_ff;
   logic             neg_ff;
   logic [63:0]      d_ff, vc_p_ff, vd_p_ff;

   prod_type    pa1, pa2, pb1, pb2, pd;
   logic [63:0] a11_ff, c22_ff, p_ff;
   logic [63:0] a11_h_ff [HOLD_DLY];
   logic [63:0] c22_h_ff [HOLD_DLY];
   logic [63:0] p_h_ff   [HOLD_DLY];
   logic        neg_h_ff [DIV_BITS];

   logic [DIV_BITS-1:0] sec;
   prod_type            pt, pm, pc;
   logic [DIV_BITS-1:0] sec_t_ff [3];
   logic [63:0]         c22_t_ff [5];
   logic                neg_t_ff [5];
   logic [63:0]         t_ff;
   logic [63:0]         m_t_ff [3];

   logic [63:0] lon_lon_ff, lat_lat_ff, lon_lat_ff;

   // pipeline advance
   assign en        = ~(v_ff[NUM_STAGES-1] & rsp_stall);
   assign req_stall = ~en;
   assign csr_ready = 1'b1;

   // scale register
   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff <= SCALE_RESET;
      end else if (csr_valid) begin
         scale_ff <= csr_wdata;
      end
   end

   // valid bits travel with the items
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NUM_STAGES; k++) v_ff[k] <= 1'b0;
      end else if (en) begin
         v_ff[0] <= req_valid;
         for (int k = 1; k < NUM_STAGES; k++) v_ff[k] <= v_ff[k-1];
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (en) begin
         bearing_ff <= req_bearing;
         lat_ff     <= req_latitude;
         sig_c_ff   <= req_sigma_cross_m;
         sig_d_ff   <= req_sigma_down_m;
      end
   end

   // sin/cos of bearing and latitude
   assign brg_phase = {bearing_ff, 16'd0};
   assign lat_phase = {lat_ff[14], lat_ff, 16'd0};

   lcr_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_cordic_brg (
      .clock   (clock),
      .en      (en),
      .phase   (brg_phase),
      .cos_q30 (ca),
      .sin_q30 (sa)
   );

   lcr_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_cordic_lat (
      .clock   (clock),
      .en      (en),
      .phase   (lat_phase),
      .cos_q30 (cl),
      .sin_q30 ()
   );

   // sigmas to radians
   always_ff @(posedge clock) begin
      if (en) begin
         sc_ff <= 48'(sig_c_ff) * 48'(scale_ff);
         sd_ff <= 48'(sig_d_ff) * 48'(scale_ff);
      end
   end

   // variances
   lcr_mul u_mul_vc (.clock(clock), .en(en), .a({16'd0, sc_ff}), .b({16'd0, sc_ff}),
                     .prod(vc_prod));
   lcr_mul u_mul_vd (.clock(clock), .en(en), .a({16'd0, sd_ff}), .b({16'd0, sd_ff}),
                     .prod(vd_prod));

   always_ff @(posedge clock) begin
      if (en) begin
         vc_ff <= shr_sat(vc_prod, 32, LIM_U64);
         vd_ff <= shr_sat(vd_prod, 32, LIM_U64);
         vc_dly_ff[0] <= vc_ff;
         vd_dly_ff[0] <= vd_ff;
         for (int k = 1; k < VC_DLY; k++) begin
            vc_dly_ff[k] <= vc_dly_ff[k-1];
            vd_dly_ff[k] <= vd_dly_ff[k-1];
         end
      end
   end

   assign vc_c = vc_dly_ff[VC_DLY-1];
   assign vd_c = vd_dly_ff[VC_DLY-1];

   // rotation factors, cosine magnitude and difference sign
   always_comb begin
      ca_abs = ca[31] ? 32'(-ca) : 32'(ca);
      sa_abs = sa[31] ? 32'(-sa) : 32'(sa);
      cl_abs = cl[31] ? 32'(-cl) : 32'(cl);
      cos_sq = 62'(ca_abs[30:0]) * 62'(ca_abs[30:0]);
      sin_sq = 62'(sa_abs[30:0]) * 62'(sa_abs[30:0]);
      cs_pr  = 62'(ca_abs[30:0]) * 62'(sa_abs[30:0]);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cos2_ff <= cos_sq[60:30];
         sin2_ff <= sin_sq[60:30];
         cs_ff   <= cs_pr[60:30];
         den_ff  <= (cl_abs[30:0] == '0) ? DEN_W'(1) : cl_abs[30:0];
         neg_ff  <= (vc_c > vd_c) ^ (ca[31] ^ sa[31]);
         d_ff    <= (vc_c > vd_c) ? vc_c - vd_c : vd_c - vc_c;
         vc_p_ff <= vc_c;
         vd_p_ff <= vd_c;
      end
   end

   // secant of latitude
   lcr_div u_div (.clock(clock), .en(en), .den(den_ff), .quot(sec));

   // rotated variance terms
   lcr_mul u_mul_a1 (.clock(clock), .en(en), .a(vc_p_ff), .b({33'd0, cos2_ff}), .prod(pa1));
   lcr_mul u_mul_a2 (.clock(clock), .en(en), .a(vd_p_ff), .b({33'd0, sin2_ff}), .prod(pa2));
   lcr_mul u_mul_b1 (.clock(clock), .en(en), .a(vc_p_ff), .b({33'd0, sin2_ff}), .prod(pb1));
   lcr_mul u_mul_b2 (.clock(clock), .en(en), .a(vd_p_ff), .b({33'd0, cos2_ff}), .prod(pb2));
   lcr_mul u_mul_d  (.clock(clock), .en(en), .a(d_ff),    .b({33'd0, cs_ff}),   .prod(pd));

   // hold the rotated terms until the secant is ready
   always_ff @(posedge clock) begin
      if (en) begin
         a11_ff <= shr_sat(pa1 + pa2, 30, LIM_U64);
         c22_ff <= shr_sat(pb1 + pb2, 30, LIM_U64);
         p_ff   <= shr_sat(pd, 30, LIM_U64);
         a11_h_ff[0] <= a11_ff;
         c22_h_ff[0] <= c22_ff;
         p_h_ff[0]   <= p_ff;
         for (int k = 1; k < HOLD_DLY; k++) begin
            a11_h_ff[k] <= a11_h_ff[k-1];
            c22_h_ff[k] <= c22_h_ff[k-1];
            p_h_ff[k]   <= p_h_ff[k-1];
         end
         neg_h_ff[0] <= neg_ff;
         for (int k = 1; k < DIV_BITS; k++) neg_h_ff[k] <= neg_h_ff[k-1];
      end
   end

   // first secant stretch and cross term
   lcr_mul u_mul_t (.clock(clock), .en(en), .a(a11_h_ff[HOLD_DLY-1]),
                    .b({{(64-DIV_BITS){1'b0}}, sec}), .prod(pt));
   lcr_mul u_mul_m (.clock(clock), .en(en), .a(p_h_ff[HOLD_DLY-1]),
                    .b({{(64-DIV_BITS){1'b0}}, sec}), .prod(pm));

   always_ff @(posedge clock) begin
      if (en) begin
         sec_t_ff[0] <= sec;
         sec_t_ff[1] <= sec_t_ff[0];
         sec_t_ff[2] <= sec_t_ff[1];
         c22_t_ff[0] <= c22_h_ff[HOLD_DLY-1];
         neg_t_ff[0] <= neg_h_ff[DIV_BITS-1];
         for (int k = 1; k < 5; k++) begin
            c22_t_ff[k] <= c22_t_ff[k-1];
            neg_t_ff[k] <= neg_t_ff[k-1];
         end
         t_ff      <= shr_sat(pt, 30, LIM_U64);
         m_t_ff[0] <= shr_sat(pm, 31, neg_t_ff[1] ? LIM_NEG : LIM_POS);
         m_t_ff[1] <= m_t_ff[0];
         m_t_ff[2] <= m_t_ff[1];
      end
   end

   // second secant stretch
   lcr_mul u_mul_c11 (.clock(clock), .en(en), .a(t_ff),
                      .b({{(64-DIV_BITS){1'b0}}, sec_t_ff[2]}), .prod(pc));

   // result register
   always_ff @(posedge clock) begin
      if (en) begin
         lon_lon_ff <= shr_sat(pc, 30, LIM_U64);
         lat_lat_ff <= c22_t_ff[4];
         lon_lat_ff <= neg_t_ff[4] ? (~m_t_ff[2] + 64'd1) : m_t_ff[2];
      end
   end

   assign rsp_valid       = v_ff[NUM_STAGES-1];
   assign rsp_cov_lon_lon = lon_lon_ff;
   assign rsp_cov_lat_lat = lat_lat_ff;
   assign rsp_cov_lon_lat = signed'(lon_lat_ff);

endmodule

[verif/tb_lonlat_covariance_rotation_top.sv]
// testbench for the lon/lat covariance rotation pipeline with a self-checking scoreboard
module tb_lonlat_covariance_rotation_top;
   import lcr_pkg::*;

   localparam int N_BITS = 16;
   localparam logic [31:0] SCALE_MAX = 32'hFFFF_FFFF;
   localparam int DRAIN_CYCLES = 120;
   localparam int LONG_HOLD = 400;

   typedef struct {
      logic [63:0] lon_lon;
      logic [63:0] lat_lat;
      logic [63:0] lon_lat;
   } cov_item_type;

   // expected covariance store and predictor
   class cov_scoreboard;
      cov_item_type pending[$];
      logic [31:0] scale;
      int errors;
      longint atan_q[24] = '{
         536870912, 316933405, 167458907, 85005780, 42667331, 21354465,
         10679838, 5340245, 2670163, 1335086, 667544, 333772,
         166886, 83443, 41721, 20860, 10430, 5215, 2607, 1303, 651, 325, 162, 81};

      function new();
         scale = SCALE_RESET;
         errors = 0;
      endfunction

      function logic [63:0] sat_shift(logic [127:0] p, int s, logic [63:0] lim);
         logic [127:0] v;
         v = p >> s;
         if (v[127:64] != 0 || v[63:0] > lim) return lim;
         return v[63:0];
      endfunction

      function logic [63:0] mul_shift(logic [63:0] a, logic [63:0] b, int s,
                                      logic [63:0] lim);
         logic [127:0] p;
         p = {64'd0, a} * {64'd0, b};
         return sat_shift(p, s, lim);
      endfunction

      function logic [63:0] magnitude(longint v);
         return v < 0 ? 64'(-v) : 64'(v);
      endfunction

      // cordic sin/cos of a binary phase, q30
      function void sin_cos(logic [31:0] phase, output longint c, output longint s);
         logic [31:0] q, r;
         longint x, y, z, dx, dy;
         x = CORDIC_K;
         y = 0;
         phase = phase & (32'hFFFF_FFFF << (32 - N_BITS));
         q = ((phase + 32'h2000_0000) >> 30) & 32'd3;
         r = phase - (q << 30);
         z = longint'(signed'(r));
         for (int i = 0; i < N_BITS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
               x -= dx; y += dy; z -= atan_q[i];
            end else begin
               x += dx; y -= dy; z += atan_q[i];
            end
         end
         if (x > ONE_Q30) x = ONE_Q30;
         if (x < -ONE_Q30) x = -ONE_Q30;
         if (y > ONE_Q30) y = ONE_Q30;
         if (y < -ONE_Q30) y = -ONE_Q30;
         case (q)
            0: begin c = x;  s = y;  end
            1: begin c = -y; s = x;  end
            2: begin c = -x; s = -y; end
            default: begin c = y; s = -x; end
         endcase
      endfunction

      // accepted input item: predict its covariance
      function void note_report(logic [15:0] bearing, logic signed [14:0] lat,
                                logic [15:0] sig_c, logic [15:0] sig_d);
         longint ca, sa, cl, sl;
         logic [31:0] lat32;
         logic [63:0] sc, sd, vc, vd, ac, as_, cos2, sin2, cs, clm, sec;
         logic [63:0] a11, d, p, m, lim;
         logic [127:0] acc;
         logic neg;
         cov_item_type e;
         sin_cos({bearing, 16'd0}, ca, sa);
         lat32 = 32'(lat);
         sin_cos(lat32 << 16, cl, sl);
         sc = 64'(sig_c) * 64'(scale);
         sd = 64'(sig_d) * 64'(scale);
         vc = mul_shift(sc, sc, 32, LIM_U64);
         vd = mul_shift(sd, sd, 32, LIM_U64);
         ac = magnitude(ca);
         as_ = magnitude(sa);
         cos2 = (ac * ac) >> 30;
         sin2 = (as_ * as_) >> 30;
         cs = (ac * as_) >> 30;
         clm = magnitude(cl);
         sec = (64'd1 << 60) / (clm == 0 ? 64'd1 : clm);
         acc = {64'd0, vc} * {64'd0, cos2} + {64'd0, vd} * {64'd0, sin2};
         a11 = sat_shift(acc, 30, LIM_U64);
         e.lon_lon = mul_shift(mul_shift(a11, sec, 30, LIM_U64), sec, 30, LIM_U64);
         acc = {64'd0, vc} * {64'd0, sin2} + {64'd0, vd} * {64'd0, cos2};
         e.lat_lat = sat_shift(acc, 30, LIM_U64);
         neg = vc > vd;
         d = neg ? vc - vd : vd - vc;
         if ((ca < 0) != (sa < 0)) neg = !neg;
         lim = neg ? LIM_NEG : LIM_POS;
         p = mul_shift(d, cs, 30, LIM_U64);
         m = mul_shift(p, sec, 31, lim);
         e.lon_lat = (neg && m != 0) ? (~m + 64'd1) : m;
         pending.push_back(e);
      endfunction

      // accepted result item: compare with the oldest prediction
      function void check_result(logic [63:0] lon_lon, logic [63:0] lat_lat,
                                 logic [63:0] lon_lat);
         cov_item_type e;
         if (pending.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result item %h %h %h",
                                       lon_lon, lat_lat, lon_lat);
            return;
         end
         e = pending.pop_front();
         if (e.lon_lon !== lon_lon || e.lat_lat !== lat_lat || e.lon_lat !== lon_lat) begin
            errors++;
            if (errors <= 10)
               $display("mismatch: exp %h %h %h got %h %h %h", e.lon_lon, e.lat_lat,
                        e.lon_lat, lon_lon, lat_lat, lon_lat);
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   logic req_valid, req_stall;
   logic [15:0] req_bearing;
   logic signed [14:0] req_latitude;
   logic [15:0] req_sigma_cross_m, req_sigma_down_m;
   logic rsp_valid, rsp_stall;
   logic [63:0] rsp_cov_lon_lon, rsp_cov_lat_lat;
   logic signed [63:0] rsp_cov_lon_lat;
   logic csr_valid, csr_ready;
   logic [31:0] csr_wdata;

   cov_scoreboard sb = new();
   int results_seen = 0;

   lonlat_covariance_rotation_top DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_bearing(req_bearing), .req_latitude(req_latitude),
      .req_sigma_cross_m(req_sigma_cross_m), .req_sigma_down_m(req_sigma_down_m),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_cov_lon_lon(rsp_cov_lon_lon), .rsp_cov_lat_lat(rsp_cov_lat_lat),
      .rsp_cov_lon_lat(rsp_cov_lon_lat),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   // idle length: mostly short, a few long
   function automatic int idle_len();
      if ($urandom_range(0, 99) < 55) return 0;
      if ($urandom_range(0, 99) < 88) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // offer one report and wait until it is taken
   task automatic send_report(logic [15:0] b, logic signed [14:0] lat,
                              logic [15:0] c, logic [15:0] d, bit calm);
      int gap;
      req_valid <= 1'b1;
      req_bearing <= b;
      req_latitude <= lat;
      req_sigma_cross_m <= c;
      req_sigma_down_m <= d;
      do @(posedge clock); while (req_stall);
      sb.note_report(b, lat, c, d);
      gap = calm ? 0 : idle_len();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // wait for the pipeline to drain, then write the scale register
   task automatic write_scale(logic [31:0] v);
      req_valid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_wdata <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      sb.scale = v;
   endtask

   function automatic logic [15:0] rand_sigma();
      case ($urandom_range(0, 3))
         0: return 16'($urandom_range(0, 255));
         1: return 16'($urandom_range(60000, 65535));
         default: return 16'($urandom_range(0, 65535));
      endcase
   endfunction

   function automatic logic signed [14:0] rand_lat();
      if ($urandom_range(0, 9) == 0) return $urandom_range(0, 1) ? 15'sd15474 : -15'sd15474;
      return 15'(int'($urandom_range(0, 30948)) - 15474);
   endfunction

   // random reports under the current scale
   task automatic random_phase(int count);
      bit calm;
      for (int i = 0; i < count; i++) begin
         if (i % 40 == 0) calm = ($urandom_range(0, 3) == 0);
         send_report(16'($urandom_range(0, 65535)), rand_lat(), rand_sigma(), rand_sigma(),
                     calm);
      end
   endtask

   // stimulus
   initial begin
      logic [31:0] scales[5];
      reset = 1'b1;
      req_valid = 1'b0;
      req_bearing = '0;
      req_latitude = '0;
      req_sigma_cross_m = '0;
      req_sigma_down_m = '0;
      csr_valid = 1'b0;
      csr_wdata = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // directed: quadrant bearings, latitude extremes, pole, equal and extreme sigmas
      send_report(16'd0, 15'sd0, 16'd100, 16'd2000, 0);
      send_report(16'd16384, 15'sd0, 16'd100, 16'd2000, 0);
      send_report(16'd32768, 15'sd0, 16'd100, 16'd2000, 0);
      send_report(16'd49152, 15'sd0, 16'd100, 16'd2000, 0);
      send_report(16'd65535, 15'sd0, 16'd2000, 16'd100, 0);
      send_report(16'd8192, 15'sd0, 16'd2000, 16'd100, 0);
      send_report(16'd24576, 15'sd4096, 16'd2000, 16'd100, 0);
      send_report(16'd40960, -15'sd4096, 16'd500, 16'd500, 0);
      send_report(16'd57344, 15'sd15474, 16'd0, 16'd0, 0);
      send_report(16'd12345, -15'sd15474, 16'd65535, 16'd65535, 0);
      send_report(16'd12345, 15'sd16383, 16'd10, 16'd20, 0);
      send_report(16'd12345, 15'sh4000, 16'd10, 16'd20, 0);
      send_report(16'd12345, 15'sh4000, 16'd0, 16'd0, 0);
      send_report(16'd777, 15'sd15474, 16'd65535, 16'd0, 0);
      send_report(16'd43690, 15'sd10922, 16'd0, 16'd65535, 0);
      send_report(16'd21845, -15'sd1, 16'd1, 16'd1, 0);
      send_report(16'd1, 15'sd1, 16'd65535, 16'd1, 0);
      random_phase(120);
      scales[0] = 32'd0;
      scales[1] = SCALE_MAX;
      scales[2] = $urandom();
      scales[3] = 32'd1;
      scales[4] = SCALE_RESET;
      foreach (scales[k]) begin
         write_scale(scales[k]);
         send_report(16'd5000, 15'sd15474, 16'd65535, 16'd0, 0);
         send_report(16'd60000, -15'sd8000, 16'd0, 16'd65535, 0);
         random_phase(k == 4 ? 120 : 100);
      end
      req_valid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end

   // result side: random stalls, one long hold-off, check every accepted item
   initial begin
      int stall_left, hold_left;
      bit calm, held;
      stall_left = 0;
      hold_left = 0;
      calm = 0;
      held = 0;
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            sb.check_result(rsp_cov_lon_lon, rsp_cov_lat_lat, rsp_cov_lon_lat);
            results_seen++;
         end
         if (!held && results_seen == 150) begin
            held = 1;
            hold_left = LONG_HOLD;
         end
         if ($urandom_range(0, 199) == 0) calm = !calm;
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            stall_left = calm ? 0 : idle_len();
            rsp_stall <= (stall_left > 0);
            if (stall_left > 0) stall_left--;
         end
      end
   end

   // overall time limit
   initial begin
      #2000000;
      $display("status: fail");
      $finish;
   end

endmodule
